// ===== design/jss_pkg.sv =====
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types and constants of the Jacobi stencil sweep block.
// ----------------------------------------------------------------------------
package jss_pkg;

   localparam int VALUE_W    = 32;   // signed Q8.24 solution and source values
   localparam int SPACING_W  = 32;   // unsigned Q0.32 h*h
   localparam int IDX_W      = 10;   // grid_interior and output indices
   localparam int REQ_DATA_W = 64;   // old_value, source_value
   localparam int RSP_DATA_W = 56;   // new_value, row_index, column_index, pad
   localparam int CSR_IDX_W  = 4;
   localparam int FIFO_DEPTH = 4;

   localparam logic [IDX_W-1:0]     GRID_INTERIOR_RESET   = 10'd1022;
   localparam logic [SPACING_W-1:0] SPACING_SQUARED_RESET = 32'd65281;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_INTERIOR   = 4'd0,
      CSR_SPACING_SQUARED = 4'd1
   } csr_index_type;

   // One line store word: the two previous rows of u and the previous row of f.
   typedef struct packed {
      logic signed [VALUE_W-1:0] older;
      logic signed [VALUE_W-1:0] newer;
      logic signed [VALUE_W-1:0] source;
   } line_word_type;

   // Bookkeeping that travels with a point down the pipeline.
   typedef struct packed {
      logic             emit;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } stencil_meta_type;

   typedef struct packed {
      logic                      last;
      logic [IDX_W-1:0]          col;
      logic [IDX_W-1:0]          row;
      logic signed [VALUE_W-1:0] value;
   } result_type;

endpackage

// ===== design/jacobi_stencil_sweep.sv =====
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep
// One Jacobi sweep of the 5-point stencil over a raster-ordered grid stream.
// ----------------------------------------------------------------------------
// The block takes the (N+2)x(N+2) grid, boundary included, one point per beat
// in raster order, and returns one beat for every interior point with
// new = (h2*f + up + left + down + right) / 4, rounded to nearest (ties
// upward) and saturated to signed Q8.24. It sustains one point per clock
// while the output queue has room: the only shared resource is a single line
// memory, read at the column of the arriving point and written back at that
// same column in the next cycle, and consecutive points always hit different
// columns, so no interlock is ever needed. A result for interior point (r, c)
// is registered in stage 1 and stage 2 after grid point (r+1, c+1) is
// accepted and leaves, with ready high, through a four-entry output queue;
// the input stalls only when that queue plus the two pipeline stages would
// overflow. The line memory is not cleared after reset: its entries are read
// for results only once two full rows have been written. Writing
// grid_interior restarts the sweep at grid point (0, 0); the user must write
// configuration only while the block is idle; the block does not enforce it.
// After the last grid point the sweep wraps and the next one begins.
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep #(
   parameter int MAX_SIDE = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // slave side: [31:0] old_value, [63:32] source_value
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [jss_pkg::REQ_DATA_W-1:0]       req_tdata,
   // master side: [31:0] new_value, [41:32] row_index, [51:42] column_index,
   // [55:52] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [jss_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [jss_pkg::SPACING_W-1:0]        csr_data
);
   import jss_pkg::*;

   localparam int CW    = $clog2(MAX_SIDE);   // column / row counter and address
   localparam int SW    = CW + 1;             // holds the side length itself
   localparam int CMP_W = ((SW > IDX_W) ? SW : IDX_W) + 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   // Configuration registers.
   logic [IDX_W-1:0]     grid_ff;
   logic [SPACING_W-1:0] spacing_ff;
   logic                 csr_grid_write;

   // Sweep position of the next accepted point.
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   // Window and hold registers that supply left, up, down and f.
   logic signed [VALUE_W-1:0] window_left_ff, window_centre_ff;
   logic signed [VALUE_W-1:0] up_hold_ff, down_hold_ff, source_hold_ff;

   // Stage 1: memory read data is valid.
   logic                      s1_valid_ff;
   stencil_meta_type          s1_meta_ff;
   logic [CW-1:0]             s1_col_ff;
   logic signed [VALUE_W-1:0] s1_cur_ff, s1_src_ff;

   logic             accept;
   logic [SW-1:0]    side;
   logic [CMP_W-1:0] n_ext, n_clamped;
   logic [SW-1:0]    r_cur, c_cur, r_nxt, c_nxt;
   logic [SW-1:0]    r_m1, c_m1;
   stencil_meta_type meta_in;

   line_word_type rd_word, wr_word;

   logic                 dp_busy;
   logic                 res_valid;
   result_type           res_data;
   result_type           out_data;
   logic [CNT_W-1:0]     fifo_count;
   logic [CNT_W+1:0]     in_flight;

   assign csr_ready      = 1'b1;
   assign csr_grid_write = csr_valid && (csr_index == CSR_GRID_INTERIOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff    <= GRID_INTERIOR_RESET;
         spacing_ff <= SPACING_SQUARED_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_INTERIOR:   grid_ff    <= csr_data[IDX_W-1:0];
            CSR_SPACING_SQUARED: spacing_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Side length: N clamped to 1..MAX_SIDE-2, plus two boundary points.
   always_comb begin
      n_ext = CMP_W'(grid_ff);
      if (n_ext == '0) begin
         n_clamped = CMP_W'(1);
      end else if (n_ext > CMP_W'(MAX_SIDE - 2)) begin
         n_clamped = CMP_W'(MAX_SIDE - 2);
      end else begin
         n_clamped = n_ext;
      end
      side = SW'(n_clamped + CMP_W'(2));
   end

   // Admission: everything in the pipeline must find room in the queue.
   assign in_flight  = (CNT_W+2)'(fifo_count) + (CNT_W+2)'(s1_valid_ff)
                     + (CNT_W+2)'(dp_busy);
   assign req_tready = (in_flight < (CNT_W+2)'(FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      r_cur = SW'(row_ff);
      c_cur = SW'(col_ff);
      if (r_cur >= side || c_cur >= side) begin
         r_cur = '0;
         c_cur = '0;
      end
      r_nxt = r_cur;
      c_nxt = c_cur + SW'(1);
      if (c_nxt >= side) begin
         c_nxt = '0;
         r_nxt = r_cur + SW'(1);
         if (r_nxt >= side) begin
            r_nxt = '0;
         end
      end
      r_m1         = r_cur - SW'(1);
      c_m1         = c_cur - SW'(1);
      meta_in.emit = (r_cur >= SW'(2)) && (c_cur >= SW'(2));
      meta_in.last = (r_cur == side - SW'(1)) && (c_cur == side - SW'(1));
      meta_in.row  = IDX_W'(r_m1);
      meta_in.col  = IDX_W'(c_m1);

      row_in = row_ff;
      col_in = col_ff;
      if (csr_grid_write) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         row_in = CW'(r_nxt);
         col_in = CW'(c_nxt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_meta_ff <= meta_in;
         s1_col_ff  <= CW'(c_cur);
         s1_cur_ff  <= $signed(req_tdata[VALUE_W-1:0]);
         s1_src_ff  <= $signed(req_tdata[2*VALUE_W-1:VALUE_W]);
      end
   end

   // The window shifts and the holds load as each point leaves stage 1.
   always_ff @(posedge clock) begin
      if (reset || csr_grid_write) begin
         window_left_ff   <= '0;
         window_centre_ff <= '0;
         up_hold_ff       <= '0;
         down_hold_ff     <= '0;
         source_hold_ff   <= '0;
      end else if (s1_valid_ff) begin
         window_left_ff   <= window_centre_ff;
         window_centre_ff <= rd_word.newer;
         up_hold_ff       <= rd_word.older;
         down_hold_ff     <= s1_cur_ff;
         source_hold_ff   <= rd_word.source;
      end
   end

   // Write-back: the newer row ages into the older one at the same column.
   assign wr_word.older  = rd_word.newer;
   assign wr_word.newer  = s1_cur_ff;
   assign wr_word.source = s1_src_ff;

   jss_line_store #(
      .DEPTH (MAX_SIDE)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (CW'(c_cur)),
      .rd_data (rd_word),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word)
   );

   jss_stencil_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_meta   (s1_meta_ff),
      .source    (source_hold_ff),
      .spacing   (spacing_ff),
      .up        (up_hold_ff),
      .left      (window_left_ff),
      .down      (down_hold_ff),
      .right     (rd_word.newer),
      .busy      (dp_busy),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   jss_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop       (rsp_tvalid && rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_tdata = {(RSP_DATA_W - VALUE_W - 2*IDX_W)'(0), out_data.col, out_data.row,
                       out_data.value};
   assign rsp_tlast = out_data.last;

endmodule

// ===== design/jss_line_store.sv =====
// ----------------------------------------------------------------------------
// jss_line_store
// Single-port-per-direction line memory with a registered read port.
// ----------------------------------------------------------------------------
module jss_line_store #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output jss_pkg::line_word_type              rd_data,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  jss_pkg::line_word_type              wr_data
);
   import jss_pkg::*;

   line_word_type line_mem_ff [DEPTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/jss_stencil_datapath.sv =====
// ----------------------------------------------------------------------------
// jss_stencil_datapath
// Two-stage arithmetic: h2*f product and neighbour sum, then round and saturate.
// ----------------------------------------------------------------------------
module jss_stencil_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  jss_pkg::stencil_meta_type              in_meta,
   input  logic signed [jss_pkg::VALUE_W-1:0]     source,
   input  logic [jss_pkg::SPACING_W-1:0]          spacing,
   input  logic signed [jss_pkg::VALUE_W-1:0]     up,
   input  logic signed [jss_pkg::VALUE_W-1:0]     left,
   input  logic signed [jss_pkg::VALUE_W-1:0]     down,
   input  logic signed [jss_pkg::VALUE_W-1:0]     right,
   output logic                                   busy,
   output logic                                   res_valid,
   output jss_pkg::result_type                    res_data
);
   import jss_pkg::*;

   localparam int SUM_W  = VALUE_W + 2;
   localparam int PROD_W = 2 * VALUE_W;
   localparam int ACC_W  = SUM_W + 3;

   logic                     s2_valid_ff;
   stencil_meta_type         s2_meta_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [SUM_W-1:0]  nsum_ff;
   logic signed [SUM_W-1:0]  nsum_in;
   logic signed [PROD_W:0]   prod_full;
   logic signed [PROD_W-1:0] prod_shifted;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-5:0]  rounded;
   logic signed [VALUE_W-1:0] saturated;

   // The spacing is unsigned, so it enters the signed product with a zero on top.
   always_comb begin
      prod_full = source * $signed({1'b0, spacing});
      prod_in   = prod_full[PROD_W-1:0];
      nsum_in   = {{2{up[VALUE_W-1]}}, up} + {{2{left[VALUE_W-1]}}, left}
                + {{2{down[VALUE_W-1]}}, down} + {{2{right[VALUE_W-1]}}, right};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid;
      end
      s2_meta_ff <= in_meta;
      prod_ff    <= prod_in;
      nsum_ff    <= nsum_in;
   end

   // floor((P/2^30 + 4*sum + 8) / 16), rounding to nearest with ties upward.
   always_comb begin
      prod_shifted = prod_ff >>> 30;
      acc = prod_shifted[ACC_W-1:0]
          + {nsum_ff[SUM_W-1], nsum_ff, 2'b00}
          + ACC_W'(8);
      rounded = acc[ACC_W-1:4];
      if (rounded[ACC_W-5:VALUE_W-1] == '0 || rounded[ACC_W-5:VALUE_W-1] == '1) begin
         saturated = rounded[VALUE_W-1:0];
      end else if (rounded[ACC_W-5]) begin
         saturated = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         saturated = {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

   assign busy           = s2_valid_ff;
   assign res_valid      = s2_valid_ff & s2_meta_ff.emit;
   assign res_data.last  = s2_meta_ff.last;
   assign res_data.col   = s2_meta_ff.col;
   assign res_data.row   = s2_meta_ff.row;
   assign res_data.value = saturated;

endmodule

// ===== design/jss_result_fifo.sv =====
// ----------------------------------------------------------------------------
// jss_result_fifo
// Small output queue that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
module jss_result_fifo (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        push,
   input  jss_pkg::result_type                         push_data,
   input  logic                                        pop,
   output logic                                        out_valid,
   output jss_pkg::result_type                         out_data,
   output logic [$clog2(jss_pkg::FIFO_DEPTH+1)-1:0]    count
);
   import jss_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   result_type       entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== design/jss_checker.sv =====
// ----------------------------------------------------------------------------
// jss_checker
// Port-level checks on the Jacobi stencil sweep, bound to the top level.
// ----------------------------------------------------------------------------
module jss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [jss_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [jss_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [jss_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [jss_pkg::SPACING_W-1:0]   csr_data
);
   import jss_pkg::*;

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Only interior points are reported, so both indices are one-based.
   a_rsp_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[41:32] != 10'd0 && rsp_tdata[51:42] != 10'd0)
      else $error("result beat for a boundary point");

   // The final point of a sweep is the corner (N, N).
   a_rsp_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[41:32] == rsp_tdata[51:42])
      else $error("last flag away from the diagonal corner");

   // Reset empties the output queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat offered right after reset");

endmodule

bind jacobi_stencil_sweep jss_checker u_jss_checker (.*);
